[design/eusv_pkg.sv]
// package: shared types, widths, register indexes and reset values
`timescale 1ns / 1ps
`default_nettype none

package eusv_pkg;

    // field and datapath widths
    localparam int ENC_BITS_DEF = 15;
    localparam int TURN_W       = 17;
    localparam int POS_W        = 32;
    localparam int DIST_W       = POS_W + 1;
    localparam int SPEED_W      = 16;
    localparam int RATE_W       = 17;
    localparam int ZOFF_W       = 16;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 3;

    // turn detection band and speed floor
    localparam int TURN_THRESHOLD = 1000;
    localparam int MIN_SPEED      = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DRIVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 3'd4;

    // sweep direction
    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // configuration register set
    typedef struct packed {
        logic signed [POS_W-1:0]   upper_limit;
        logic signed [POS_W-1:0]   lower_limit;
        logic        [SPEED_W-1:0] max_speed;
        logic                      reverse_drive;
        logic signed [ZOFF_W-1:0]  zero_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        upper_limit:   32'sd6800,
        lower_limit:   32'sd250,
        max_speed:     16'd1000,
        reverse_drive: 1'b1,
        zero_offset:   16'sd27000
    };

    // sweep stage to speed stage
    typedef struct packed {
        logic        [DIST_W-1:0] d1;
        logic signed [DIST_W-1:0] d2;
        logic                     down;
        logic        [POS_W-1:0]  upos;
    } swp_t;

endpackage

`default_nettype wire

[design/eusv_in_if.sv]
// interface: encoder sample channel
`timescale 1ns / 1ps
`default_nettype none

interface eusv_in_if #(
    parameter int ENC_BITS = eusv_pkg::ENC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [ENC_BITS-1:0] raw_count;

    modport source (output valid, output raw_count, input ready);
    modport sink (input valid, input raw_count, output ready);
endinterface

`default_nettype wire

[design/eusv_out_if.sv]
// interface: drive result channel
`timescale 1ns / 1ps
`default_nettype none

interface eusv_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [eusv_pkg::RATE_W-1:0]  drive_rate;
    logic signed [eusv_pkg::POS_W-1:0]   position;
    logic                                moving_down;

    modport source (output valid, output drive_rate, output position, output moving_down,
                    input ready);
    modport sink (input valid, input drive_rate, input position, input moving_down,
                  output ready);
endinterface

`default_nettype wire

[design/eusv_cfg_regs.sv]
// configuration register file with write port
`timescale 1ns / 1ps
`default_nettype none

module eusv_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [eusv_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [eusv_pkg::CFG_DATA_W-1:0]   wr_data,
    output eusv_pkg::cfg_t                    cfg
);
    import eusv_pkg::*;

    cfg_t cfg_reg;

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_UPPER_LIMIT:   cfg_reg.upper_limit   <= wr_data[POS_W-1:0];
                REG_LOWER_LIMIT:   cfg_reg.lower_limit   <= wr_data[POS_W-1:0];
                REG_MAX_SPEED:     cfg_reg.max_speed     <= wr_data[SPEED_W-1:0];
                REG_REVERSE_DRIVE: cfg_reg.reverse_drive <= wr_data[0];
                REG_ZERO_OFFSET:   cfg_reg.zero_offset   <= wr_data[ZOFF_W-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[design/eusv_unwrap.sv]
// stage 1: turn counting and unwrapped position
`timescale 1ns / 1ps
`default_nettype none

module eusv_unwrap #(
    parameter int ENC_BITS = eusv_pkg::ENC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  eusv_pkg::cfg_t                cfg,
    eusv_in_if.sink                       sample,
    output logic                          s1_valid,
    output logic [eusv_pkg::POS_W-1:0]    s1_upos,
    input  logic                          s1_ready
);
    import eusv_pkg::*;

    // turn band edges; for narrow encoders a band may cover the whole range
    localparam int HIGH_MARK = (1 << ENC_BITS) - 1 - TURN_THRESHOLD;
    localparam logic HIGH_ALL = (HIGH_MARK < 0);
    localparam logic [ENC_BITS-1:0] HIGH_VAL = HIGH_ALL ? '0 : ENC_BITS'(HIGH_MARK);
    localparam logic LOW_ALL = ((1 << ENC_BITS) <= TURN_THRESHOLD);
    localparam logic [ENC_BITS-1:0] LOW_VAL = LOW_ALL ? '0 : ENC_BITS'(TURN_THRESHOLD);

    logic                have_prev_reg;
    logic [ENC_BITS-1:0] prev_reg;
    logic [TURN_W-1:0]   turn_reg;
    logic                s1_valid_reg;
    logic [POS_W-1:0]    upos_reg;

    logic                accept;
    logic                now_high;
    logic                now_low;
    logic                prev_high;
    logic                prev_low;
    logic                turn_down;
    logic                turn_up;
    logic [TURN_W-1:0]   turn_next;
    logic [POS_W-1:0]    upos_next;
    logic [POS_W-1:0]    offset_ext;

    assign sample.ready = !s1_valid_reg || s1_ready;
    assign accept       = sample.valid && sample.ready;

    // wrap detection against the previous sample
    assign now_high  = HIGH_ALL || (sample.raw_count > HIGH_VAL);
    assign now_low   = LOW_ALL || (sample.raw_count < LOW_VAL);
    assign prev_high = HIGH_ALL || (prev_reg > HIGH_VAL);
    assign prev_low  = LOW_ALL || (prev_reg < LOW_VAL);
    assign turn_down = (sample.raw_count > prev_reg) && now_high && prev_low;
    assign turn_up   = (sample.raw_count < prev_reg) && now_low && prev_high;

    always_comb
    begin
        turn_next = turn_reg;
        if (turn_up)
        begin
            turn_next = turn_reg + TURN_W'(1);
        end
        else if (turn_down)
        begin
            turn_next = turn_reg - TURN_W'(1);
        end
    end

    // position = raw + turns * 2^bits - zero offset, mod 2^32
    assign offset_ext = {{(POS_W-ZOFF_W){cfg.zero_offset[ZOFF_W-1]}}, cfg.zero_offset};
    assign upos_next  = POS_W'(sample.raw_count)
                      + POS_W'({turn_next, {ENC_BITS{1'b0}}})
                      - offset_ext;

    // turn state and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            turn_reg      <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                have_prev_reg <= 1'b1;
                prev_reg      <= sample.raw_count;
                if (have_prev_reg)
                begin
                    turn_reg <= turn_next;
                end
            end
            if (sample.ready)
            begin
                s1_valid_reg <= accept && have_prev_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upos_reg <= upos_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_upos  = upos_reg;

endmodule

`default_nettype wire

[design/eusv_sweep.sv]
// stage 2: sweep direction, reversal point and distances
`timescale 1ns / 1ps
`default_nettype none

module eusv_sweep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  eusv_pkg::cfg_t                cfg,
    input  logic                          s1_valid,
    input  logic [eusv_pkg::POS_W-1:0]    s1_upos,
    output logic                          s1_ready,
    output logic                          s2_valid,
    output eusv_pkg::swp_t                s2,
    input  logic                          s2_ready
);
    import eusv_pkg::*;

    dir_t                     dir_reg;
    logic signed [POS_W-1:0]  rev_reg;
    logic                     s2_valid_reg;
    swp_t                     s2_reg;

    logic                     load;
    logic signed [POS_W-1:0]  pos;
    dir_t                     dir_eff;
    dir_t                     dir_new;
    logic signed [POS_W-1:0]  rev_eff;
    logic signed [POS_W-1:0]  rev_new;
    logic                     flip;
    logic signed [DIST_W-1:0] diff;
    logic        [DIST_W-1:0] d1;
    logic signed [DIST_W-1:0] dist_up;
    logic signed [DIST_W-1:0] dist_down;
    swp_t                     s2_next;

    assign s1_ready = !s2_valid_reg || s2_ready;
    assign load     = s1_valid && s1_ready;
    assign pos      = s1_upos;

    // first result starts the sweep upward at the current position
    assign dir_eff = (dir_reg == DIR_IDLE) ? DIR_UP : dir_reg;
    assign rev_eff = (dir_reg == DIR_IDLE) ? pos : rev_reg;

    // reversal once the limit ahead is passed
    assign flip    = ((dir_eff == DIR_UP) && (pos > cfg.upper_limit))
                  || ((dir_eff == DIR_DOWN) && (pos < cfg.lower_limit));
    assign dir_new = flip ? ((dir_eff == DIR_UP) ? DIR_DOWN : DIR_UP) : dir_eff;
    assign rev_new = flip ? pos : rev_eff;

    // distance from reversal point, zero right at a reversal
    assign diff = {rev_eff[POS_W-1], rev_eff} - {pos[POS_W-1], pos};
    assign d1   = flip ? '0 : (diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff));

    // distance to the limit ahead, may be negative
    assign dist_up   = {cfg.upper_limit[POS_W-1], cfg.upper_limit} - {pos[POS_W-1], pos};
    assign dist_down = {pos[POS_W-1], pos} - {cfg.lower_limit[POS_W-1], cfg.lower_limit};

    always_comb
    begin
        s2_next.d1   = d1;
        s2_next.d2   = (dir_new == DIR_UP) ? dist_up : dist_down;
        s2_next.down = (dir_new == DIR_DOWN);
        s2_next.upos = s1_upos;
    end

    // sweep state and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg      <= DIR_IDLE;
            rev_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                dir_reg <= dir_new;
                rev_reg <= rev_new;
            end
            if (s1_ready)
            begin
                s2_valid_reg <= s1_valid;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

`default_nettype wire

[design/eusv_speed.sv]
// stage 3: speed select, clamp, sign and result register
`timescale 1ns / 1ps
`default_nettype none

module eusv_speed (
    input  logic              clk,
    input  logic              rst_n,
    input  eusv_pkg::cfg_t    cfg,
    input  logic              s2_valid,
    input  eusv_pkg::swp_t    s2,
    output logic              s2_ready,
    eusv_out_if.source        result
);
    import eusv_pkg::*;

    logic                     out_valid_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic signed [POS_W-1:0]  pos_reg;
    logic                     down_reg;

    logic                     load;
    logic        [DIST_W-1:0] near;
    logic        [DIST_W-1:0] floored;
    logic        [SPEED_W-1:0] mag;
    logic                     negate;
    logic signed [RATE_W-1:0] rate_next;

    assign s2_ready = !out_valid_reg || result.ready;
    assign load     = s2_valid && s2_ready;

    // lesser distance; a negative distance to the limit drops to the floor
    always_comb
    begin
        if (s2.d2[DIST_W-1])
        begin
            near = '0;
        end
        else if (s2.d1 < DIST_W'(s2.d2))
        begin
            near = s2.d1;
        end
        else
        begin
            near = DIST_W'(s2.d2);
        end
    end

    // floor first, max speed clamp last
    assign floored = (near < DIST_W'(MIN_SPEED)) ? DIST_W'(MIN_SPEED) : near;
    assign mag     = (floored > DIST_W'(cfg.max_speed)) ? cfg.max_speed
                                                        : floored[SPEED_W-1:0];

    // sign by direction and drive polarity
    assign negate    = s2.down ^ cfg.reverse_drive;
    assign rate_next = negate ? -RATE_W'(mag) : RATE_W'(mag);

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s2_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rate_reg <= rate_next;
            pos_reg  <= s2.upos;
            down_reg <= s2.down;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.drive_rate  = rate_reg;
    assign result.position    = pos_reg;
    assign result.moving_down = down_reg;

endmodule

`default_nettype wire

[design/encoder_unwrap_sweep_velocity.sv]
// top level: encoder unwrap and sweep velocity pipeline
// a result word is valid once its sample word has passed the unwrap, sweep and result registers
// throughput: one sample word per cycle while the result port does not stall, three register stages
// the first sample after reset only primes the turn counter and gives no result
// reset (async, active low) clears valid, turn and sweep state and loads
// the register defaults
`timescale 1ns / 1ps
`default_nettype none

module encoder_unwrap_sweep_velocity #(
    parameter int ENCODER_BITS = eusv_pkg::ENC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [eusv_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [eusv_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    eusv_in_if.sink                           sample,
    eusv_out_if.source                        result
);
    import eusv_pkg::*;

    cfg_t              cfg;
    logic              s1_valid;
    logic [POS_W-1:0]  s1_upos;
    logic              s1_ready;
    logic              s2_valid;
    swp_t              s2;
    logic              s2_ready;

    // configuration registers
    eusv_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_wr_index),
        .wr_data  (cfg_wr_data),
        .cfg      (cfg)
    );

    // turn counting and position
    eusv_unwrap #(
        .ENC_BITS (ENCODER_BITS)
    ) u_unwrap (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .sample   (sample),
        .s1_valid (s1_valid),
        .s1_upos  (s1_upos),
        .s1_ready (s1_ready)
    );

    // sweep direction and distances
    eusv_sweep u_sweep (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s1_valid (s1_valid),
        .s1_upos  (s1_upos),
        .s1_ready (s1_ready),
        .s2_valid (s2_valid),
        .s2       (s2),
        .s2_ready (s2_ready)
    );

    // speed and result register
    eusv_speed u_speed (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s2_valid (s2_valid),
        .s2       (s2),
        .s2_ready (s2_ready),
        .result   (result)
    );

endmodule

`default_nettype wire

[design/eusv_checker.sv]
// checker: port-level assertions, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module eusv_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              sample_valid,
    input logic                              sample_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic signed [eusv_pkg::RATE_W-1:0] drive_rate,
    input logic signed [eusv_pkg::POS_W-1:0]  position,
    input logic                              moving_down
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(drive_rate) && $stable(position) && $stable(moving_down))
    else $error("stalled result word changed");

    // no result word right out of reset
    assert property (@(posedge clk) $rose(rst_n) |-> !result_valid)
    else $error("result word valid out of reset");

    // with the result register empty the pipeline takes a sample word
    assert property (@(posedge clk) !result_valid |-> sample_ready)
    else $error("sample stalled while result register empty");

    // drive rate word never takes the most negative value of its width
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (drive_rate != {1'b1, {(eusv_pkg::RATE_W-1){1'b0}}}))
    else $error("drive rate word out of range");

endmodule

bind encoder_unwrap_sweep_velocity eusv_checker u_eusv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .drive_rate   (result.drive_rate),
    .position     (result.position),
    .moving_down  (result.moving_down)
);

`default_nettype wire
